// File: rtl/fsmgc_pkg.sv
// Shared types and codes of the flash segment manager.
// Used by the front decoder, the command queue, the back engine and the top level.
`default_nettype none
package fsmgc_pkg;

  // Command codes as they arrive on the input channel
  localparam logic [3:0] CMD_OPEN    = 4'd0;
  localparam logic [3:0] CMD_NEXT    = 4'd1;
  localparam logic [3:0] CMD_SET     = 4'd2;
  localparam logic [3:0] CMD_INVAL   = 4'd3;
  localparam logic [3:0] CMD_CLEAR   = 4'd4;
  localparam logic [3:0] CMD_QUERY   = 4'd5;
  localparam logic [3:0] CMD_VICTIM  = 4'd6;
  localparam logic [3:0] CMD_TRIM    = 4'd7;
  localparam logic [3:0] CMD_GC      = 4'd8;

  // Result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NO_FREE    = 2'd1;
  localparam logic [1:0] STAT_FULL       = 2'd2;
  localparam logic [1:0] STAT_NO_INVALID = 2'd3;

  // Invalid page total per segment, saturating
  localparam int         TOT_W   = 11;
  localparam logic [10:0] TOT_MAX = 11'd2047;

  // Width that holds the segment of any page address
  localparam int PSEG_W = 10;

  typedef enum logic [3:0] {
    OP_OPEN, OP_NEXT, OP_SET, OP_INVAL, OP_CLEAR, OP_QUERY,
    OP_VICTIM, OP_TRIM, OP_GC, OP_NONE
  } op_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t               op;
    logic [15:0]       page;
    logic [5:0]        seg;
    logic [PSEG_W-1:0] pseg;     // segment that holds page
    logic              page_ok;  // page lies inside flash
    logic              seg_ok;   // seg lies inside flash
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/fsmgc_front.sv
// Front end: accepts input words, decodes the command and finds the page's segment.
// Three-stage pipeline; depends on fsmgc_pkg.
`default_nettype none
module fsmgc_front #(
  parameter int PAGES_PER_BLOCK    = 256,
  parameter int BLOCKS_PER_SEGMENT = 4,
  parameter int SEGMENT_COUNT      = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [3:0]      in_cmd,
  input  wire logic [15:0]     in_page,
  input  wire logic [5:0]      in_seg,
  output logic                 push,
  output fsmgc_pkg::cmd_t      push_data,
  input  wire logic            full
);

  localparam int SEG_PAGES = BLOCKS_PER_SEGMENT * PAGES_PER_BLOCK;
  localparam longint TOTAL = longint'(SEGMENT_COUNT) * SEG_PAGES;
  localparam logic [16:0] TOTAL17 = (TOTAL >= 65536) ? 17'h10000 : 17'(TOTAL);
  localparam logic [10:0] N11 = 11'(SEGMENT_COUNT);
  // floor(2^32 / SEG_PAGES): quotient estimate is exact or one low
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SEG_PAGES);

  logic            v1_r, v2_r, v3_r;
  fsmgc_pkg::cmd_t c1_r, c2_r, c3_r;
  logic [47:0]     prod2_r;
  logic [15:0]     q3_r;
  logic [31:0]     qd3_r;
  logic            adv;
  fsmgc_pkg::op_t  op_dec;
  logic [31:0]     rem;
  logic [15:0]     quo;

  assign adv      = !(v3_r && full);
  assign in_ready = adv;
  assign push     = v3_r && !full;

  // Command decode
  always_comb begin
    case (in_cmd)
      fsmgc_pkg::CMD_OPEN:   op_dec = fsmgc_pkg::OP_OPEN;
      fsmgc_pkg::CMD_NEXT:   op_dec = fsmgc_pkg::OP_NEXT;
      fsmgc_pkg::CMD_SET:    op_dec = fsmgc_pkg::OP_SET;
      fsmgc_pkg::CMD_INVAL:  op_dec = fsmgc_pkg::OP_INVAL;
      fsmgc_pkg::CMD_CLEAR:  op_dec = fsmgc_pkg::OP_CLEAR;
      fsmgc_pkg::CMD_QUERY:  op_dec = fsmgc_pkg::OP_QUERY;
      fsmgc_pkg::CMD_VICTIM: op_dec = fsmgc_pkg::OP_VICTIM;
      fsmgc_pkg::CMD_TRIM:   op_dec = fsmgc_pkg::OP_TRIM;
      fsmgc_pkg::CMD_GC:     op_dec = fsmgc_pkg::OP_GC;
      default:               op_dec = fsmgc_pkg::OP_NONE;
    endcase
  end

  // Quotient correction: one compare after the reciprocal estimate
  always_comb begin
    rem = 32'(c3_r.page) - qd3_r;
    quo = q3_r + 16'(rem >= 32'(SEG_PAGES));
    push_data      = c3_r;
    push_data.pseg = fsmgc_pkg::PSEG_W'(quo);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r.op      <= op_dec;
      c1_r.page    <= in_page;
      c1_r.seg     <= in_seg;
      c1_r.pseg    <= '0;
      c1_r.page_ok <= {1'b0, in_page} < TOTAL17;
      c1_r.seg_ok  <= {5'd0, in_seg} < N11;
      c2_r         <= c1_r;
      prod2_r      <= 48'(c1_r.page) * 48'(RECIP);
      c3_r         <= c2_r;
      q3_r         <= prod2_r[47:32];
      qd3_r        <= 32'(prod2_r[47:32]) * 32'(SEG_PAGES);
    end
  end

endmodule
`default_nettype wire

// File: rtl/fsmgc_fifo.sv
// Two-entry command queue between front and back end.
// Depends on fsmgc_pkg for the command type.
`default_nettype none
module fsmgc_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire fsmgc_pkg::cmd_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output fsmgc_pkg::cmd_t      pop_data,
  output logic                 empty
);

  fsmgc_pkg::cmd_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/fsmgc_back.sv
// Back end: executes commands against the bitmap, block and segment memories.
// Holds the free segment queue and the result register; depends on fsmgc_pkg.
`default_nettype none
module fsmgc_back #(
  parameter int PAGES_PER_BLOCK    = 256,
  parameter int BLOCKS_PER_SEGMENT = 4,
  parameter int SEGMENT_COUNT      = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            f_empty,
  input  wire fsmgc_pkg::cmd_t f_data,
  output logic                 f_pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [39:0]          out_tdata
);

  localparam int PPB       = PAGES_PER_BLOCK;
  localparam int BPS       = BLOCKS_PER_SEGMENT;
  localparam int N         = SEGMENT_COUNT;
  localparam int SEG_PAGES = BPS * PPB;
  localparam int TOTAL     = N * SEG_PAGES;
  localparam int MAP_DEPTH = (TOTAL < 65536) ? TOTAL : 65536;
  localparam int MAP_W     = $clog2(MAP_DEPTH);
  localparam int BLK_TOTAL = N * BPS;
  localparam int BLK_W     = $clog2(BLK_TOTAL);
  localparam int SEG_W     = $clog2(N);
  localparam int CNT_W     = SEG_W + 1;
  localparam int CUR_W     = (BPS > 1) ? $clog2(BPS) : 1;
  localparam int WP_W      = $clog2(PPB + 1);
  localparam int K_W       = $clog2(SEG_PAGES);
  localparam int TW        = fsmgc_pkg::TOT_W;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_NP_WP, ST_VSCAN, ST_TRIM
  } state_t;

  // Memories
  logic             bm_mem   [MAP_DEPTH];
  logic [WP_W-1:0]  bk_mem   [BLK_TOTAL];
  logic [TW-1:0]    stot_mem [N];
  logic [CUR_W-1:0] scur_mem [N];
  logic             suse_mem [N];
  logic [SEG_W-1:0] fq_mem   [N];

  logic             bm_we, bm_wd, bm_rd_r;
  logic [MAP_W-1:0] bm_wa, bm_ra;
  logic             bk_we;
  logic [BLK_W-1:0] bk_wa, bk_ra;
  logic [WP_W-1:0]  bk_wd, bk_rd_r;
  logic             stot_we;
  logic [SEG_W-1:0] stot_wa, stot_ra;
  logic [TW-1:0]    stot_wd, stot_rd_r;
  logic             scur_we;
  logic [SEG_W-1:0] scur_wa, scur_ra;
  logic [CUR_W-1:0] scur_wd, scur_rd_r;
  logic             suse_we, suse_wd, suse_rd_r;
  logic [SEG_W-1:0] suse_wa, suse_ra;
  logic             fq_we;
  logic [SEG_W-1:0] fq_wa, fq_ra, fq_wd, fq_rd_r;

  // Control registers
  state_t           state_r, state_nxt;
  fsmgc_pkg::cmd_t  c_r, c_nxt;
  logic [MAP_W-1:0] init_r, init_nxt;
  logic [SEG_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CUR_W-1:0] cur_r, cur_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic             adv_r, adv_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [SEG_W-1:0] scan_r, scan_nxt, best_r, best_nxt;
  logic [TW-1:0]    btot_r, btot_nxt;
  logic             found_r, found_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       os_r, os_nxt;
  logic [15:0]      oa_r, oa_nxt;
  logic [5:0]       og_r, og_nxt;
  logic [TW-1:0]    oc_r, oc_nxt;
  logic             ob_r, ob_nxt;

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, ob_r, oc_r, og_r, oa_r, os_r};

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_rd_r <= bm_mem[bm_ra];
  end
  always_ff @(posedge clk) begin
    if (bk_we) bk_mem[bk_wa] <= bk_wd;
    bk_rd_r <= bk_mem[bk_ra];
  end
  always_ff @(posedge clk) begin
    if (stot_we) stot_mem[stot_wa] <= stot_wd;
    stot_rd_r <= stot_mem[stot_ra];
  end
  always_ff @(posedge clk) begin
    if (scur_we) scur_mem[scur_wa] <= scur_wd;
    scur_rd_r <= scur_mem[scur_ra];
  end
  always_ff @(posedge clk) begin
    if (suse_we) suse_mem[suse_wa] <= suse_wd;
    suse_rd_r <= suse_mem[suse_ra];
  end
  always_ff @(posedge clk) begin
    if (fq_we) fq_mem[fq_wa] <= fq_wd;
    fq_rd_r <= fq_mem[fq_ra];
  end

  // Command sequencer
  always_comb begin
    logic             fin;
    logic [1:0]       r_st;
    logic [15:0]      r_addr;
    logic [5:0]       r_seg;
    logic [TW-1:0]    r_cnt;
    logic             r_bit;
    logic [SEG_W-1:0] seg_ix, f_seg_ix, pseg_ix, tail;
    logic [CNT_W-1:0] qsum;
    logic [31:0]      blk_base, trim_start, pg;
    logic [BLK_W-1:0] blk;
    logic             take, nf;
    logic [SEG_W-1:0] nb;
    logic [TW-1:0]    nt;

    fin = 1'b0; r_st = fsmgc_pkg::STAT_OK; r_addr = '0; r_seg = '0; r_cnt = '0; r_bit = 1'b0;
    seg_ix     = SEG_W'(c_r.seg);
    f_seg_ix   = SEG_W'(f_data.seg);
    pseg_ix    = c_r.pseg[SEG_W-1:0];
    blk_base   = 32'(seg_ix) * 32'(BPS);
    trim_start = 32'(seg_ix) * 32'(SEG_PAGES);
    pg         = trim_start + 32'(k_r);
    blk        = '0;
    qsum       = CNT_W'(head_r) + cnt_r;
    if (qsum >= CNT_W'(N)) qsum = qsum - CNT_W'(N);
    tail       = qsum[SEG_W-1:0];
    take = 1'b0; nf = 1'b0; nb = best_r; nt = btot_r;

    state_nxt = state_r; c_nxt = c_r; init_nxt = init_r; head_nxt = head_r; cnt_nxt = cnt_r;
    cur_nxt = cur_r; blk_nxt = blk_r; adv_nxt = adv_r; k_nxt = k_r; scan_nxt = scan_r;
    best_nxt = best_r; btot_nxt = btot_r; found_nxt = found_r;
    ov_nxt = ov_r; os_nxt = os_r; oa_nxt = oa_r; og_nxt = og_r; oc_nxt = oc_r; ob_nxt = ob_r;
    f_pop = 1'b0;

    bm_we = 1'b0; bm_wa = c_r.page[MAP_W-1:0]; bm_wd = 1'b0; bm_ra = f_data.page[MAP_W-1:0];
    bk_we = 1'b0; bk_wa = blk_r; bk_wd = '0; bk_ra = blk_r;
    stot_we = 1'b0; stot_wa = seg_ix; stot_wd = '0; stot_ra = f_data.pseg[SEG_W-1:0];
    scur_we = 1'b0; scur_wa = seg_ix; scur_wd = '0; scur_ra = f_seg_ix;
    suse_we = 1'b0; suse_wa = seg_ix; suse_wd = 1'b0; suse_ra = '0;
    fq_we = 1'b0; fq_wa = tail; fq_wd = seg_ix; fq_ra = head_r;

    if (ov_r && out_tready) ov_nxt = 1'b0;

    case (state_r)
      // Clearing pass over every memory, queue filled with 0..N-1
      ST_INIT: begin
        bm_we = 1'b1;
        bm_wa = init_r;
        if (32'(init_r) < BLK_TOTAL) begin
          bk_we = 1'b1;
          bk_wa = init_r[BLK_W-1:0];
        end
        if (32'(init_r) < N) begin
          stot_we = 1'b1; stot_wa = init_r[SEG_W-1:0];
          scur_we = 1'b1; scur_wa = init_r[SEG_W-1:0];
          suse_we = 1'b1; suse_wa = init_r[SEG_W-1:0];
          fq_we   = 1'b1; fq_wa   = init_r[SEG_W-1:0]; fq_wd = init_r[SEG_W-1:0];
        end
        if (init_r == MAP_W'(MAP_DEPTH - 1)) state_nxt = ST_IDLE;
        else init_nxt = init_r + 1'b1;
      end

      // Take the next command once the result slot is free
      ST_IDLE: begin
        if (!f_empty && (!ov_r || out_tready)) begin
          f_pop = 1'b1;
          c_nxt = f_data;
          if (f_data.op == fsmgc_pkg::OP_VICTIM) begin
            stot_ra   = '0;
            scan_nxt  = '0;
            found_nxt = 1'b0;
            best_nxt  = '0;
            btot_nxt  = '0;
            state_nxt = ST_VSCAN;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end

      // First data cycle of every command but victim
      ST_EXEC: begin
        case (c_r.op)
          fsmgc_pkg::OP_OPEN: begin
            fin = 1'b1;
            if (cnt_r == '0) begin
              r_st = fsmgc_pkg::STAT_NO_FREE;
            end else begin
              suse_we = 1'b1; suse_wa = fq_rd_r; suse_wd = 1'b1;
              scur_we = 1'b1; scur_wa = fq_rd_r;
              head_nxt = (head_r == SEG_W'(N - 1)) ? '0 : head_r + 1'b1;
              cnt_nxt  = cnt_r - 1'b1;
              r_seg    = 6'(fq_rd_r);
            end
          end
          fsmgc_pkg::OP_NEXT: begin
            if (!c_r.seg_ok) begin
              fin  = 1'b1;
              r_st = fsmgc_pkg::STAT_FULL;
            end else begin
              blk       = BLK_W'(blk_base + 32'(scur_rd_r));
              bk_ra     = blk;
              blk_nxt   = blk;
              cur_nxt   = scur_rd_r;
              adv_nxt   = 1'b0;
              state_nxt = ST_NP_WP;
            end
          end
          fsmgc_pkg::OP_SET, fsmgc_pkg::OP_INVAL, fsmgc_pkg::OP_CLEAR,
          fsmgc_pkg::OP_QUERY: begin
            fin = 1'b1;
            if (c_r.page_ok) begin
              if (c_r.op == fsmgc_pkg::OP_SET) begin
                r_bit = !bm_rd_r;
                bm_we = 1'b1;
                bm_wd = 1'b1;
              end else begin
                r_bit = bm_rd_r;
                bm_we = c_r.op != fsmgc_pkg::OP_QUERY;
              end
              // Invalidate counts even when the page was already clear
              if (c_r.op == fsmgc_pkg::OP_INVAL) begin
                stot_we = 1'b1;
                stot_wa = pseg_ix;
                stot_wd = (stot_rd_r == fsmgc_pkg::TOT_MAX) ? stot_rd_r : stot_rd_r + 1'b1;
              end
            end
          end
          fsmgc_pkg::OP_TRIM: begin
            if (c_r.seg_ok) begin
              k_nxt     = '0;
              state_nxt = ST_TRIM;
            end else begin
              fin = 1'b1;
            end
          end
          fsmgc_pkg::OP_GC: begin
            fin   = 1'b1;
            r_bit = cnt_r == '0;
          end
          default: fin = 1'b1;
        endcase
      end

      // Write pointer check, one cursor advance at most
      ST_NP_WP: begin
        if (32'(bk_rd_r) < PPB) begin
          fin    = 1'b1;
          bk_we  = 1'b1;
          bk_wd  = bk_rd_r + 1'b1;
          r_addr = 16'(32'(blk_r) * 32'(PPB) + 32'(bk_rd_r));
        end else if (adv_r || cur_r == CUR_W'(BPS - 1)) begin
          fin  = 1'b1;
          r_st = fsmgc_pkg::STAT_FULL;
        end else begin
          cur_nxt = cur_r + 1'b1;
          blk_nxt = blk_r + 1'b1;
          bk_ra   = blk_r + 1'b1;
          scur_we = 1'b1;
          scur_wd = cur_r + 1'b1;
          adv_nxt = 1'b1;
        end
      end

      // Greedy scan, one segment per cycle, ties keep the lowest index
      ST_VSCAN: begin
        take = suse_rd_r && (!found_r || stot_rd_r > btot_r);
        nb   = take ? scan_r : best_r;
        nt   = take ? stot_rd_r : btot_r;
        nf   = found_r || suse_rd_r;
        best_nxt  = nb;
        btot_nxt  = nt;
        found_nxt = nf;
        if (scan_r == SEG_W'(N - 1)) begin
          fin = 1'b1;
          if (!nf) begin
            r_st = fsmgc_pkg::STAT_NO_INVALID;
          end else begin
            r_seg = 6'(nb);
            r_cnt = nt;
            if (nt == '0) begin
              r_st = fsmgc_pkg::STAT_NO_INVALID;
            end else begin
              suse_we = 1'b1;
              suse_wa = nb;
            end
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
          stot_ra  = scan_r + 1'b1;
          suse_ra  = scan_r + 1'b1;
        end
      end

      // Wipe pages, blocks and counters of the segment and requeue it if the free queue has room, one page per cycle
      ST_TRIM: begin
        if (pg < 32'(MAP_DEPTH)) begin
          bm_we = 1'b1;
          bm_wa = pg[MAP_W-1:0];
        end
        if (32'(k_r) < BPS) begin
          bk_we = 1'b1;
          bk_wa = BLK_W'(blk_base + 32'(k_r));
        end
        if (k_r == '0) begin
          stot_we = 1'b1;
          scur_we = 1'b1;
          suse_we = 1'b1;
          if (cnt_r < CNT_W'(N)) begin
            fq_we   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        if (k_r == K_W'(SEG_PAGES - 1)) begin
          fin    = 1'b1;
          r_addr = 16'(trim_start);
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (fin) begin
      state_nxt = ST_IDLE;
      ov_nxt = 1'b1;
      os_nxt = r_st;
      oa_nxt = r_addr;
      og_nxt = r_seg;
      oc_nxt = r_cnt;
      ob_nxt = r_bit;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      init_r  <= '0;
      head_r  <= '0;
      cnt_r   <= CNT_W'(N);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    c_r     <= c_nxt;
    cur_r   <= cur_nxt;
    blk_r   <= blk_nxt;
    adv_r   <= adv_nxt;
    k_r     <= k_nxt;
    scan_r  <= scan_nxt;
    best_r  <= best_nxt;
    btot_r  <= btot_nxt;
    found_r <= found_nxt;
    os_r    <= os_nxt;
    oa_r    <= oa_nxt;
    og_r    <= og_nxt;
    oc_r    <= oc_nxt;
    ob_r    <= ob_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/flash_segment_manager_greedy_gc.sv
// Flash segment manager with greedy GC victim choice: top level.
// Input channel carries one command per word (in_tuser = command code,
// in_tdata = page address and segment index); every command returns exactly
// one result word on the output channel, in command order.
// Front end: three-stage decoder that also finds the page's segment with a
// reciprocal multiply; it accepts one word per cycle into a two-entry queue until
// it is full, and keeps accepting while the back end works or the result waits.
// Back end: one command at a time against registered-read memories.
//   open, set, invalidate, clear, query, gc needed: idle, then execute
//   next page: idle, execute, pointer check, and a second check on a block change
//   victim: idle, then the scan state (one segment read per cycle)
//   trim: idle, execute, then the trim state (one bitmap write per page)
// An accepted word passes the three front stages and the queue, then the back end.
// After reset a clearing pass over the min(total pages, 65536) bitmap entries wipes
// the bitmap and counters and fills the free queue; commands queue up meanwhile.
// A stalled receiver holds the result word; the back end takes no new command
// until it is taken, and the front stalls once its queue is full.
// Depends on fsmgc_pkg, fsmgc_front, fsmgc_fifo and fsmgc_back.
`default_nettype none
module flash_segment_manager_greedy_gc #(
  parameter int PAGES_PER_BLOCK    = 256,
  parameter int BLOCKS_PER_SEGMENT = 4,
  parameter int SEGMENT_COUNT      = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // page_address[15:0], segment_index[21:16]
  input  wire logic [3:0]  in_tuser,   // command[3:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // status[1:0], result_address[17:2],
                                       // result_segment[23:18], invalid_count[34:24],
                                       // bit_result[35]
);

  logic            push, full, pop, empty;
  fsmgc_pkg::cmd_t push_data, pop_data;

  fsmgc_front #(
    .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
    .BLOCKS_PER_SEGMENT(BLOCKS_PER_SEGMENT),
    .SEGMENT_COUNT(SEGMENT_COUNT)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tuser), .in_page(in_tdata[15:0]), .in_seg(in_tdata[21:16]),
    .push(push), .push_data(push_data), .full(full)
  );

  fsmgc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data), .full(full),
    .pop(pop), .pop_data(pop_data), .empty(empty)
  );

  fsmgc_back #(
    .PAGES_PER_BLOCK(PAGES_PER_BLOCK),
    .BLOCKS_PER_SEGMENT(BLOCKS_PER_SEGMENT),
    .SEGMENT_COUNT(SEGMENT_COUNT)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .f_empty(empty), .f_data(pop_data), .f_pop(pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the flash segment manager with greedy GC.
// Depends on fsmgc_pkg for command and status codes; drives and checks the
// stream ports of flash_segment_manager_greedy_gc only.
`timescale 1ns / 100ps

// Result word fields
typedef struct packed {
  logic [0:0]  bitr;
  logic [10:0] cnt;
  logic [5:0]  rseg;
  logic [15:0] raddr;
  logic [1:0]  status;
} seg_result_t;

// Mirror of the segment manager state plus the queue of predicted words
class seg_scoreboard;
  bit          vmap[65536];
  logic [8:0]  blk_inv[256];
  logic [9:0]  blk_wp[256];
  logic [10:0] seg_tot[64];
  logic [1:0]  seg_cur[64];
  bit          seg_used[64];
  logic [5:0]  freeq[64];
  int          free_cnt;
  int          head;
  seg_result_t pending_q[$];
  int          errors;

  function new();
    for (int i = 0; i < 65536; i++) vmap[i] = 0;
    for (int i = 0; i < 256; i++) begin
      blk_inv[i] = '0;
      blk_wp[i]  = '0;
    end
    for (int i = 0; i < 64; i++) begin
      seg_tot[i]  = '0;
      seg_cur[i]  = '0;
      seg_used[i] = 0;
      freeq[i]    = i[5:0];
    end
    free_cnt = 64;
    head     = 0;
    errors   = 0;
  endfunction

  // Apply one accepted command and queue the word it must produce
  function void note(logic [3:0] cmd, logic [15:0] addr, logic [5:0] seg);
    seg_result_t r;
    int base, cur, blk, s, best;
    bit found, was;
    r = '0;
    base = seg * 4;
    case (cmd)
      fsmgc_pkg::CMD_OPEN: begin
        if (free_cnt == 0) r.status = fsmgc_pkg::STAT_NO_FREE;
        else begin
          s = freeq[head];
          head = (head + 1) % 64;
          free_cnt--;
          seg_used[s] = 1;
          seg_cur[s] = '0;
          r.rseg = s[5:0];
        end
      end
      fsmgc_pkg::CMD_NEXT: begin
        cur = seg_cur[seg];
        if (cur == 3 && blk_wp[base + 3] >= 256) r.status = fsmgc_pkg::STAT_FULL;
        else begin
          if (blk_wp[base + cur] >= 256) cur++;
          seg_cur[seg] = cur[1:0];
          if (blk_wp[base + cur] >= 256) r.status = fsmgc_pkg::STAT_FULL;
          else begin
            r.raddr = 16'((base + cur) * 256 + blk_wp[base + cur]);
            blk_wp[base + cur]++;
          end
        end
      end
      fsmgc_pkg::CMD_SET, fsmgc_pkg::CMD_INVAL, fsmgc_pkg::CMD_CLEAR,
      fsmgc_pkg::CMD_QUERY: begin
        was = vmap[addr];
        blk = addr / 256;
        if (cmd == fsmgc_pkg::CMD_SET) begin
          r.bitr = !was;
          vmap[addr] = 1;
        end else begin
          r.bitr = was;
          if (cmd != fsmgc_pkg::CMD_QUERY) vmap[addr] = 0;
          // invalidate counts even on a page that was already clear
          if (cmd == fsmgc_pkg::CMD_INVAL) begin
            s = blk / 4;
            if (blk_inv[blk] < 9'd511) blk_inv[blk]++;
            if (seg_tot[s] < fsmgc_pkg::TOT_MAX) seg_tot[s]++;
          end
        end
      end
      fsmgc_pkg::CMD_VICTIM: begin
        found = 0;
        best = 0;
        for (int i = 0; i < 64; i++)
          if (seg_used[i] && (!found || seg_tot[i] > seg_tot[best])) begin
            best = i;
            found = 1;
          end
        if (!found) r.status = fsmgc_pkg::STAT_NO_INVALID;
        else begin
          r.rseg = best[5:0];
          r.cnt = seg_tot[best];
          if (seg_tot[best] == 0) r.status = fsmgc_pkg::STAT_NO_INVALID;
          else seg_used[best] = 0;
        end
      end
      fsmgc_pkg::CMD_TRIM: begin
        for (int i = 0; i < 4; i++) begin
          blk_inv[base + i] = '0;
          blk_wp[base + i] = '0;
        end
        for (int p = 0; p < 1024; p++) vmap[seg * 1024 + p] = 0;
        seg_tot[seg] = '0;
        seg_cur[seg] = '0;
        seg_used[seg] = 0;
        if (free_cnt < 64) begin
          freeq[(head + free_cnt) % 64] = seg;
          free_cnt++;
        end
        r.raddr = 16'(seg * 1024);
      end
      fsmgc_pkg::CMD_GC: r.bitr = (free_cnt == 0);
      default: ;
    endcase
    pending_q.push_back(r);
  endfunction

  // Compare a result word with the oldest prediction
  function void check(logic [39:0] data);
    seg_result_t got, exp;
    got = data[35:0];
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, data);
      errors++;
      return;
    end
    exp = pending_q.pop_front();
    if (got.status !== exp.status) begin
      $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      errors++;
    end
    if (got.raddr !== exp.raddr) begin
      $display("%0t: result_address exp %h got %h", $time, exp.raddr, got.raddr);
      errors++;
    end
    if (got.rseg !== exp.rseg) begin
      $display("%0t: result_segment exp %0d got %0d", $time, exp.rseg, got.rseg);
      errors++;
    end
    if (got.cnt !== exp.cnt) begin
      $display("%0t: invalid_count exp %0d got %0d", $time, exp.cnt, got.cnt);
      errors++;
    end
    if (got.bitr !== exp.bitr) begin
      $display("%0t: bit_result exp %0d got %0d", $time, exp.bitr, got.bitr);
      errors++;
    end
  endfunction
endclass

module tb_top;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // page_address[15:0], segment_index[21:16]
  logic [3:0]  in_tuser = '0;   // command[3:0]
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;       // status, result_address, result_segment,
                                // invalid_count, bit_result
  bit          quiet = 0;
  seg_scoreboard sb = new();

  flash_segment_manager_greedy_gc dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // Send one command word; called and returns at a falling edge
  task automatic send_cmd(input logic [3:0] cmd, input logic [15:0] addr,
                          input logic [5:0] seg);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, seg, addr};
    do @(posedge clk); while (!in_tready);
    sb.note(cmd, addr, seg);
    @(negedge clk);
  endtask

  // Page near the start of one of the commonly used segments
  function automatic logic [15:0] hot_page();
    return 16'($urandom_range(0, 15) * 1024 + $urandom_range(0, 300));
  endfunction

  // One random command, mostly well-formed allocate/mark/collect traffic
  task automatic random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)      send_cmd(fsmgc_pkg::CMD_OPEN, 16'($urandom), 6'($urandom));
    else if (r < 40) send_cmd(fsmgc_pkg::CMD_NEXT, 16'($urandom),
                              ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 15))
                                                          : 6'($urandom));
    else if (r < 54) send_cmd(fsmgc_pkg::CMD_SET, hot_page(), 6'($urandom));
    else if (r < 67) send_cmd(fsmgc_pkg::CMD_INVAL, hot_page(), 6'($urandom));
    else if (r < 72) send_cmd(fsmgc_pkg::CMD_CLEAR, hot_page(), 6'($urandom));
    else if (r < 80) send_cmd(fsmgc_pkg::CMD_QUERY,
                              ($urandom_range(0, 1) != 0) ? hot_page() : 16'($urandom),
                              6'($urandom));
    else if (r < 86) send_cmd(fsmgc_pkg::CMD_VICTIM, 16'($urandom), 6'($urandom));
    else if (r < 89) send_cmd(fsmgc_pkg::CMD_TRIM, 16'($urandom),
                              6'($urandom_range(0, 15)));
    else if (r < 92) send_cmd(fsmgc_pkg::CMD_GC, 16'($urandom), 6'($urandom));
    else if (r < 95) send_cmd(4'($urandom_range(9, 15)), 16'($urandom), 6'($urandom));
    else             send_cmd(4'($urandom_range(0, 15)), 16'($urandom), 6'($urandom));
  endtask

  // Receiver with random stall bursts
  initial begin
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      out_tready <= 1;
      @(negedge clk);
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);

  // Stimulus
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: every command, field extremes, special cases
    send_cmd(fsmgc_pkg::CMD_VICTIM, 16'h0000, 6'd0);       // nothing in use
    send_cmd(fsmgc_pkg::CMD_GC, 16'h0000, 6'd0);
    send_cmd(fsmgc_pkg::CMD_OPEN, 16'hFFFF, 6'd63);
    send_cmd(fsmgc_pkg::CMD_VICTIM, 16'h0000, 6'd0);       // in use, zero invalid
    send_cmd(fsmgc_pkg::CMD_NEXT, 16'h0000, 6'd0);
    send_cmd(fsmgc_pkg::CMD_NEXT, 16'h0000, 6'd63);        // segment not in use
    send_cmd(fsmgc_pkg::CMD_SET, 16'h0000, 6'd0);
    send_cmd(fsmgc_pkg::CMD_SET, 16'h0000, 6'd0);          // already set
    send_cmd(fsmgc_pkg::CMD_SET, 16'hFFFF, 6'd0);
    send_cmd(fsmgc_pkg::CMD_QUERY, 16'hFFFF, 6'd0);
    send_cmd(fsmgc_pkg::CMD_QUERY, 16'h8000, 6'd0);
    send_cmd(fsmgc_pkg::CMD_INVAL, 16'h0000, 6'd0);
    send_cmd(fsmgc_pkg::CMD_INVAL, 16'h0000, 6'd0);        // already clear, still counted
    send_cmd(fsmgc_pkg::CMD_CLEAR, 16'hFFFF, 6'd0);
    send_cmd(fsmgc_pkg::CMD_CLEAR, 16'hFFFF, 6'd0);
    send_cmd(fsmgc_pkg::CMD_OPEN, 16'h0000, 6'd0);
    send_cmd(fsmgc_pkg::CMD_VICTIM, 16'h0000, 6'd0);
    send_cmd(fsmgc_pkg::CMD_VICTIM, 16'h0000, 6'd0);
    send_cmd(fsmgc_pkg::CMD_TRIM, 16'h0000, 6'd63);
    send_cmd(fsmgc_pkg::CMD_TRIM, 16'h0000, 6'd0);
    send_cmd(fsmgc_pkg::CMD_TRIM, 16'h0000, 6'd1);         // queue full: wipe only
    send_cmd(4'd9, 16'hFFFF, 6'd63);
    send_cmd(4'd15, 16'hAAAA, 6'd21);
    send_cmd(fsmgc_pkg::CMD_GC, 16'hFFFF, 6'd63);

    // random body with a few well-formed bursts
    for (int n = 0; n < 470; n++) begin
      if (n == 100) begin
        // drain the free queue, then refill part of it
        for (int k = 0; k < 70; k++)
          send_cmd(fsmgc_pkg::CMD_OPEN, 16'($urandom), 6'($urandom));
        send_cmd(fsmgc_pkg::CMD_GC, 16'($urandom), 6'($urandom));
        send_cmd(fsmgc_pkg::CMD_TRIM, 16'($urandom), 6'd40);
        send_cmd(fsmgc_pkg::CMD_GC, 16'($urandom), 6'($urandom));
      end
      if (n == 200) begin
        // walk one segment across a block boundary
        for (int k = 0; k < 270; k++)
          send_cmd(fsmgc_pkg::CMD_NEXT, 16'($urandom), 6'd5);
      end
      if (n == 300) begin
        // pile invalid pages onto one block
        for (int k = 0; k < 30; k++)
          send_cmd(fsmgc_pkg::CMD_INVAL, 16'h1200 | 16'($urandom_range(0, 255)),
                   6'($urandom));
        send_cmd(fsmgc_pkg::CMD_VICTIM, 16'($urandom), 6'($urandom));
      end
      if (n == 410) quiet = 1;
      random_cmd();
    end
    in_tvalid <= 0;

    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: filelist.f
rtl/fsmgc_pkg.sv
rtl/fsmgc_front.sv
rtl/fsmgc_fifo.sv
rtl/fsmgc_back.sv
rtl/flash_segment_manager_greedy_gc.sv
test/tb_top.sv
